@@ rtl/tpq_pkg.sv @@
// Shared types, widths and product tables for the triangle plane quadric pipeline.
`default_nettype none
package tpq_pkg;

	localparam int CoordW = 32;
	localparam int EdgeW = CoordW + 1;
	localparam int LoW = 17;
	localparam int HiW = EdgeW - LoW;
	localparam int PlW = EdgeW + LoW + 1;
	localparam int PhW = EdgeW + HiW;
	localparam int CrossW = 2 * EdgeW + 1;
	localparam int BlW = $clog2(CrossW + 1);
	localparam int UW = 30;
	localparam int SqW = 2 * UW;
	localparam int SumW = SqW + 2;
	localparam int RootW = SumW / 2;
	localparam int NFrac = 30;
	localparam int NumW = UW + NFrac + 1;
	localparam int QW = RootW;
	localparam int NW = 32;
	localparam int AccW = 64;
	localparam int DShift = 14;
	localparam int HalfW = 25;
	localparam int MagW = 2 * HalfW;
	localparam int ProdW = 2 * MagW;
	localparam int OutW = 64;
	localparam int NumCoef = 10;

	// Operand 0..2 are the normal components, operand 3 is the offset d.
	localparam int OpA [NumCoef] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
	localparam int OpB [NumCoef] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
	localparam int ShTab [NumCoef] = '{28, 28, 28, 30, 28, 28, 30, 28, 30, 32};

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [OutW-1:0] coef_t;
	typedef logic signed [CrossW-1:0] cross_t;
	typedef logic [UW-1:0] u_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
	} tri_t;

	typedef struct packed {
		coef_t q_aa;
		coef_t q_ab;
		coef_t q_ac;
		coef_t q_ad;
		coef_t q_bb;
		coef_t q_bc;
		coef_t q_bd;
		coef_t q_cc;
		coef_t q_cd;
		coef_t q_dd;
		logic degenerate;
	} quad_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} pt_t;

	typedef struct packed {
		logic [2:0] sg;
		logic degen;
		pt_t a;
	} div_tag_t;

	typedef struct packed {
		u_t [2:0] u;
		div_tag_t d;
	} sq_tag_t;

endpackage
`default_nettype wire

@@ rtl/tpq_tri_if.sv @@
// Stream interface that carries one triangle per transaction.
`default_nettype none
interface tpq_tri_if import tpq_pkg::*; ();
	logic valid;
	logic ready;
	tri_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/tpq_quad_if.sv @@
// Stream interface that carries one plane quadric per transaction.
`default_nettype none
interface tpq_quad_if import tpq_pkg::*; ();
	logic valid;
	logic ready;
	quad_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/tpq_cross.sv @@
// Edge vectors and exact cross product, four pipeline stages.
`default_nettype none
module tpq_cross import tpq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  tri_t   tri_d,
	output logic   out_valid,
	output cross_t xp [3],
	output pt_t    corner
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [EdgeW-1:0] e1_s1 [3];
	logic signed [EdgeW-1:0] e2_s1 [3];
	pt_t a_s1, a_s2, a_s3, a_s4;
	logic signed [EdgeW-1:0] pa [6];
	logic signed [EdgeW-1:0] pb [6];
	logic signed [PlW-1:0] pl_s2 [6];
	logic signed [PhW-1:0] ph_s2 [6];
	logic signed [CrossW-1:0] pr_s3 [6];
	cross_t xp_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1[0] <= EdgeW'(tri_d.b_x) - EdgeW'(tri_d.a_x);
			e1_s1[1] <= EdgeW'(tri_d.b_y) - EdgeW'(tri_d.a_y);
			e1_s1[2] <= EdgeW'(tri_d.b_z) - EdgeW'(tri_d.a_z);
			e2_s1[0] <= EdgeW'(tri_d.c_x) - EdgeW'(tri_d.a_x);
			e2_s1[1] <= EdgeW'(tri_d.c_y) - EdgeW'(tri_d.a_y);
			e2_s1[2] <= EdgeW'(tri_d.c_z) - EdgeW'(tri_d.a_z);
			a_s1 <= '{x: tri_d.a_x, y: tri_d.a_y, z: tri_d.a_z};
			a_s2 <= a_s1;
			a_s3 <= a_s2;
			a_s4 <= a_s3;
		end
	end

	// Each component is the difference of two products; even slots hold the positive one.
	for (genvar i = 0; i < 3; i++) begin : g_pair
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		assign pa[2*i]   = e1_s1[J];
		assign pb[2*i]   = e2_s1[K];
		assign pa[2*i+1] = e1_s1[K];
		assign pb[2*i+1] = e2_s1[J];
	end

	// The 33-bit second operand of each product is split into an unsigned low part and a signed high part.
	for (genvar m = 0; m < 6; m++) begin : g_mul
		always_ff @(posedge clk) begin
			if (en) begin
				pl_s2[m] <= PlW'(pa[m]) * PlW'($signed({1'b0, pb[m][LoW-1:0]}));
				ph_s2[m] <= PhW'(pa[m]) * PhW'($signed(pb[m][EdgeW-1:LoW]));
				pr_s3[m] <= (CrossW'(ph_s2[m]) <<< LoW) + CrossW'(pl_s2[m]);
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_diff
		always_ff @(posedge clk) begin
			if (en) begin
				xp_s4[i] <= pr_s3[2*i] - pr_s3[2*i+1];
			end
		end
		assign xp[i] = xp_s4[i];
	end

	assign out_valid = v_s4;
	assign corner = a_s4;

endmodule
`default_nettype wire

@@ rtl/tpq_norm.sv @@
// Scales the cross product to 30 bits and forms the sum of squares, five stages.
`default_nettype none
module tpq_norm import tpq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  cross_t          xp [3],
	input  pt_t             corner,
	output logic            out_valid,
	output sq_tag_t         tag,
	output logic [SumW-1:0] sum
);

	function automatic logic [BlW-1:0] bitlen(input logic [CrossW-1:0] v);
		logic [BlW-1:0] n;
		n = '0;
		for (int b = 0; b < CrossW; b++) begin
			if (v[b]) begin
				n = BlW'(b + 1);
			end
		end
		return n;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [CrossW-1:0] mag_s1 [3];
	logic [CrossW-1:0] mag_s2 [3];
	logic [2:0] sg_s1, sg_s2;
	pt_t a_s1, a_s2;
	logic [BlW-1:0] bl_s2;
	sq_tag_t tag_s3, tag_s4, tag_s5;
	logic [SqW-1:0] sq_s4 [3];
	logic [SumW-1:0] sum_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				mag_s1[i] <= xp[i][CrossW-1] ? -xp[i] : xp[i];
				mag_s2[i] <= mag_s1[i];
				sq_s4[i] <= SqW'(tag_s3.u[i]) * SqW'(tag_s3.u[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				sg_s1[l] <= xp[l][CrossW-1];
				// All three share the shift that brings the largest to 30 bits.
				if (bl_s2 > BlW'(UW)) begin
					tag_s3.u[l] <= UW'(mag_s2[l] >> (bl_s2 - BlW'(UW)));
				end else begin
					tag_s3.u[l] <= UW'(mag_s2[l] << (BlW'(UW) - bl_s2));
				end
			end
			a_s1 <= corner;
			a_s2 <= a_s1;
			sg_s2 <= sg_s1;
			bl_s2 <= bitlen(mag_s1[0] | mag_s1[1] | mag_s1[2]);
			tag_s3.d.sg <= sg_s2;
			tag_s3.d.degen <= (bl_s2 == '0);
			tag_s3.d.a <= a_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			sum_s5 <= SumW'(sq_s4[0]) + SumW'(sq_s4[1]) + SumW'(sq_s4[2]);
		end
	end

	assign out_valid = v_s5;
	assign tag = tag_s5;
	assign sum = sum_s5;

endmodule
`default_nettype wire

@@ rtl/tpq_sqrt.sv @@
// Integer square root, one result bit per pipeline stage.
`default_nettype none
module tpq_sqrt import tpq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [SumW-1:0]  sum,
	input  sq_tag_t          tag_in,
	output logic             out_valid,
	output logic [RootW-1:0] root,
	output sq_tag_t          tag_out
);

	logic [SumW-1:0] rem_s [RootW];
	logic [RootW-1:0] root_s [RootW];
	logic v_s [RootW];
	sq_tag_t tag_s [RootW];

	for (genvar g = 0; g < RootW; g++) begin : g_stage
		localparam int B = RootW - 1 - g;
		logic [SumW-1:0] rem_i;
		logic [SumW-1:0] trial;
		logic [RootW-1:0] root_i;
		logic v_i;
		sq_tag_t tag_i;

		if (g == 0) begin : g_first
			assign rem_i = sum;
			assign root_i = '0;
			assign v_i = in_valid;
			assign tag_i = tag_in;
		end else begin : g_next
			assign rem_i = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign v_i = v_s[g-1];
			assign tag_i = tag_s[g-1];
		end

		// (root + 2^B)^2 - root^2, with the remainder holding sum - root^2.
		assign trial = (SumW'(root_i) << (B + 1)) | (SumW'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					rem_s[g] <= rem_i - trial;
					root_s[g] <= root_i | (RootW'(1) << B);
				end else begin
					rem_s[g] <= rem_i;
					root_s[g] <= root_i;
				end
				tag_s[g] <= tag_i;
			end
		end
	end

	assign out_valid = v_s[RootW-1];
	assign root = root_s[RootW-1];
	assign tag_out = tag_s[RootW-1];

endmodule
`default_nettype wire

@@ rtl/tpq_div.sv @@
// Three restoring dividers sharing one divisor, one quotient bit per stage.
`default_nettype none
module tpq_div import tpq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [RootW-1:0] root,
	input  sq_tag_t          tag_in,
	output logic             out_valid,
	output logic [QW-1:0]    quo [3],
	output div_tag_t         tag_out
);

	localparam int DivW = NumW + 1;

	logic v_s0;
	logic [NumW-1:0] num_s0 [3];
	logic [RootW-1:0] den_s0;
	div_tag_t tag_s0;

	logic [NumW-1:0] rem_s [3][QW];
	logic [QW-1:0] q_s [3][QW];
	logic [RootW-1:0] den_s [QW];
	logic v_s [QW];
	div_tag_t tag_s [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
		end
	end

	// Numerator carries half the divisor so the quotient rounds to nearest.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				num_s0[l] <= NumW'({tag_in.u[l], NFrac'(0)}) + NumW'(root >> 1);
			end
			den_s0 <= root;
			tag_s0 <= tag_in.d;
		end
	end

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int B = QW - 1 - g;
		logic [RootW-1:0] den_i;
		logic v_i;
		div_tag_t tag_i;

		if (g == 0) begin : g_first
			assign den_i = den_s0;
			assign v_i = v_s0;
			assign tag_i = tag_s0;
		end else begin : g_next
			assign den_i = den_s[g-1];
			assign v_i = v_s[g-1];
			assign tag_i = tag_s[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[g] <= den_i;
				tag_s[g] <= tag_i;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [NumW-1:0] rem_i;
			logic [QW-1:0] q_i;
			logic [DivW-1:0] dsh;

			if (g == 0) begin : g_first
				assign rem_i = num_s0[l];
				assign q_i = '0;
			end else begin : g_next
				assign rem_i = rem_s[l][g-1];
				assign q_i = q_s[l][g-1];
			end

			assign dsh = DivW'(den_i) << B;

			always_ff @(posedge clk) begin
				if (en) begin
					if (DivW'(rem_i) >= dsh) begin
						rem_s[l][g] <= rem_i - NumW'(dsh);
						q_s[l][g] <= q_i | (QW'(1) << B);
					end else begin
						rem_s[l][g] <= rem_i;
						q_s[l][g] <= q_i;
					end
				end
			end

			if (g == QW - 1) begin : g_out
				assign quo[l] = q_s[l][g];
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign tag_out = tag_s[QW-1];

endmodule
`default_nettype wire

@@ rtl/tpq_quad.sv @@
// Plane offset and the ten rounded, saturated quadric coefficients, ten stages.
`default_nettype none
module tpq_quad import tpq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [QW-1:0] quo [3],
	input  div_tag_t      tag_in,
	output logic          out_valid,
	output quad_t         res
);

	typedef struct packed {
		logic [2:0][QW-1:0] q;
		logic [2:0] sg;
		logic degen;
	} nq_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	nq_t c_s1, c_s2, c_s3, c_s4, c_s5;
	logic deg_s6, deg_s7, deg_s8, deg_s9, deg_s10;
	pt_t a_s1;
	logic signed [NW-1:0] n_s1 [3];
	logic signed [CoordW-1:0] p_c [3];
	logic signed [AccW-1:0] np_s2 [3];
	logic signed [AccW-1:0] acc_s3;
	logic neg_s4;
	logic [AccW-1:0] dm_s4;
	logic [MagW-1:0] dq_s5;
	logic dneg_s5;
	logic [MagW-1:0] om [4];
	logic osg [4];
	coef_t coef_s10 [NumCoef];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
			{v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	assign p_c[0] = a_s1.x;
	assign p_c[1] = a_s1.y;
	assign p_c[2] = a_s1.z;

	for (genvar i = 0; i < 3; i++) begin : g_dot
		always_ff @(posedge clk) begin
			if (en) begin
				n_s1[i] <= tag_in.sg[i] ? -NW'(quo[i]) : NW'(quo[i]);
				np_s2[i] <= AccW'(n_s1[i]) * AccW'(p_c[i]);
			end
		end
	end

	// The offset is kept as magnitude and sign; its sign is opposite to the dot.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				c_s1.q[l] <= quo[l];
			end
			c_s1.sg <= tag_in.sg;
			c_s1.degen <= tag_in.degen;
			a_s1 <= tag_in.a;
			c_s2 <= c_s1;
			c_s3 <= c_s2;
			c_s4 <= c_s3;
			c_s5 <= c_s4;
			acc_s3 <= np_s2[0] + np_s2[1] + np_s2[2];
			neg_s4 <= acc_s3[AccW-1];
			dm_s4 <= acc_s3[AccW-1] ? AccW'(-acc_s3) : AccW'(acc_s3);
			dq_s5 <= MagW'((dm_s4 + (AccW'(1) << (DShift - 1))) >> DShift);
			dneg_s5 <= !neg_s4;
			deg_s6 <= c_s5.degen;
			deg_s7 <= deg_s6;
			deg_s8 <= deg_s7;
			deg_s9 <= deg_s8;
			deg_s10 <= deg_s9;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_op
		assign om[i] = MagW'(c_s5.q[i]);
		assign osg[i] = c_s5.sg[i];
	end
	assign om[3] = dq_s5;
	assign osg[3] = dneg_s5;

	for (genvar k = 0; k < NumCoef; k++) begin : g_coef
		localparam int A = OpA[k];
		localparam int B = OpB[k];
		localparam int Sh = ShTab[k];
		logic [MagW-1:0] ll_s6, lh_s6, hl_s6, hh_s6;
		logic [MagW-1:0] ll_s7, hh_s7;
		logic [MagW:0] mid_s7;
		logic [ProdW-1:0] p_s8, m_s9, lim, satv;
		logic neg_s6, neg_s7, neg_s8, neg_s9;

		assign lim = ProdW'({1'b0, {(OutW-1){1'b1}}}) + ProdW'(neg_s9);
		assign satv = (m_s9 > lim) ? lim : m_s9;

		always_ff @(posedge clk) begin
			if (en) begin
				ll_s6 <= MagW'(om[A][HalfW-1:0]) * MagW'(om[B][HalfW-1:0]);
				lh_s6 <= MagW'(om[A][HalfW-1:0]) * MagW'(om[B][MagW-1:HalfW]);
				hl_s6 <= MagW'(om[A][MagW-1:HalfW]) * MagW'(om[B][HalfW-1:0]);
				hh_s6 <= MagW'(om[A][MagW-1:HalfW]) * MagW'(om[B][MagW-1:HalfW]);
				neg_s6 <= osg[A] ^ osg[B];
				mid_s7 <= (MagW+1)'(lh_s6) + (MagW+1)'(hl_s6);
				ll_s7 <= ll_s6;
				hh_s7 <= hh_s6;
				neg_s7 <= neg_s6;
				p_s8 <= ProdW'(ll_s7) + (ProdW'(mid_s7) << HalfW) + (ProdW'(hh_s7) << MagW);
				neg_s8 <= neg_s7;
				m_s9 <= (p_s8 + (ProdW'(1) << (Sh - 1))) >> Sh;
				neg_s9 <= neg_s8;
				if (deg_s9) begin
					coef_s10[k] <= '0;
				end else if (neg_s9) begin
					coef_s10[k] <= -OutW'(satv);
				end else begin
					coef_s10[k] <= OutW'(satv);
				end
			end
		end
	end

	assign out_valid = v_s10;
	assign res.q_aa = coef_s10[0];
	assign res.q_ab = coef_s10[1];
	assign res.q_ac = coef_s10[2];
	assign res.q_ad = coef_s10[3];
	assign res.q_bb = coef_s10[4];
	assign res.q_bc = coef_s10[5];
	assign res.q_bd = coef_s10[6];
	assign res.q_cc = coef_s10[7];
	assign res.q_cd = coef_s10[8];
	assign res.q_dd = coef_s10[9];
	assign res.degenerate = deg_s10;

endmodule
`default_nettype wire

@@ rtl/triangle_plane_quadric_core.sv @@
// Triangle plane quadric: top level with the pipeline chain and output skid register.
//
// tri_in takes one triangle per transaction: three corners in signed Q16.16.
// quad_out gives one result per triangle, in order: the ten distinct
// coefficients of the plane quadric in signed Q32.32, saturated, and a flag
// that marks a triangle whose cross product is zero (all coefficients zero).
// An accepted triangle reaches quad_out through, in order: edges and cross
// product, scaling and the sum of squares, the bit-per-stage square root,
// the bit-per-stage divider that forms the unit normal, and the offset and
// the coefficient products.
// Throughput is one triangle per cycle while quad_out is ready.
// When quad_out stalls, the waiting result moves into a one-entry skid
// register and one more triangle is still accepted; after that the whole
// pipeline holds and tri_in.ready stays low until the skid register drains.
// Reset clears all valid bits; nothing else needs clearing.
`default_nettype none
module triangle_plane_quadric_core import tpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	tpq_tri_if.sink tri_in,
	tpq_quad_if.source quad_out
);

	logic en;
	logic x_valid, n_valid, r_valid, d_valid, q_valid;
	cross_t xp [3];
	pt_t corner;
	sq_tag_t n_tag, r_tag;
	logic [SumW-1:0] sum;
	logic [RootW-1:0] root;
	logic [QW-1:0] quo [3];
	div_tag_t d_tag;
	quad_t res;
	logic skid_v_q;
	quad_t skid_q;

	assign en = !skid_v_q;
	assign tri_in.ready = en;

	tpq_cross u_cross (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(tri_in.valid),
		.tri_d(tri_in.data), .out_valid(x_valid), .xp(xp), .corner(corner)
	);

	tpq_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(x_valid), .xp(xp),
		.corner(corner), .out_valid(n_valid), .tag(n_tag), .sum(sum)
	);

	tpq_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(n_valid), .sum(sum),
		.tag_in(n_tag), .out_valid(r_valid), .root(root), .tag_out(r_tag)
	);

	tpq_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(r_valid), .root(root),
		.tag_in(r_tag), .out_valid(d_valid), .quo(quo), .tag_out(d_tag)
	);

	tpq_quad u_quad (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(d_valid), .quo(quo),
		.tag_in(d_tag), .out_valid(q_valid), .res(res)
	);

	// The skid entry is always older than the last pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (quad_out.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (q_valid && !quad_out.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && q_valid && !quad_out.ready) begin
			skid_q <= res;
		end
	end

	assign quad_out.valid = skid_v_q || q_valid;
	assign quad_out.data = skid_v_q ? skid_q : res;

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !quad_out.ready |=> skid_v_q && $stable(skid_q))
		else $error("skid entry lost or changed while the output stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quad_out.valid && quad_out.data.degenerate |->
		quad_out.data.q_aa == '0 && quad_out.data.q_ad == '0 && quad_out.data.q_dd == '0)
		else $error("degenerate triangle with nonzero coefficients");

	a_square_sign: assert property (@(posedge clk) disable iff (!arst_n)
		quad_out.valid |-> !quad_out.data.q_aa[OutW-1] && !quad_out.data.q_dd[OutW-1])
		else $error("square coefficient came out negative");

endmodule
`default_nettype wire
